// ----- rtl/text_readability_counter_macros.svh -----
// assertion helpers for the checker file
`ifndef TEXT_READABILITY_COUNTER_MACROS_SVH
`define TEXT_READABILITY_COUNTER_MACROS_SVH

// clocked assertion with asynchronous active-low reset
`define TRC_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same, on the usual clk_i / rst_ni pair
`define TRC_ASSERT(label, prop, msg) \
  `TRC_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ----- rtl/trc_pkg.sv -----
`default_nettype none

package trc_pkg;

  // character codes
  localparam logic [7:0] CHAR_SPACE    = 8'h20;
  localparam logic [7:0] CHAR_PERIOD   = 8'h2E;
  localparam logic [7:0] CHAR_SEMI     = 8'h3B;
  localparam logic [7:0] CHAR_EXCLAIM  = 8'h21;
  localparam logic [7:0] CHAR_QUESTION = 8'h3F;

  // token length saturates here, meaning "longer than three"
  localparam logic [2:0] TOKEN_LONG  = 3'd4;
  localparam logic [2:0] TOKEN_SHORT = 3'd3;

  // score constants, scaled by 256 and by 1000 for rounding
  localparam logic [17:0] T1_W_SCALE = 18'd259840;   // 1.015 * 256 * 1000
  localparam logic [24:0] T2_Y_SCALE = 25'd21657600; // 84.6 * 256 * 1000
  localparam logic [8:0]  ROUND_HALF = 9'd500;
  localparam logic [9:0]  DEN_SCALE  = 10'd1000;

  localparam int unsigned SCORE_W   = 24;
  localparam int unsigned SCORE_CALC_W = 27;
  localparam logic signed [SCORE_CALC_W-1:0] SCORE_BASE = 27'sd52950;
  localparam logic signed [SCORE_CALC_W-1:0] SCORE_MAX  = 27'sd8388607;
  localparam logic signed [SCORE_CALC_W-1:0] SCORE_MIN  = -27'sd8388608;

  localparam int unsigned TOTAL_W = 16;

  typedef enum logic [5:0] {
    ST_COUNT  = 6'b000001,
    ST_LOAD1  = 6'b000010,
    ST_DIV1   = 6'b000100,
    ST_LOAD2  = 6'b001000,
    ST_DIV2   = 6'b010000,
    ST_FINISH = 6'b100000
  } trc_state_e;

  typedef struct packed {
    logic count;       // ordinary byte accepted
    logic close_text;  // final byte accepted: snapshot and clear
    logic load_t1;     // load divider for the words-per-sentence term
    logic load_t2;     // keep first quotient, load syllables-per-word term
    logic div_step;    // one quotient bit
    logic publish;     // write the output register
  } trc_cmd_t;

  typedef struct packed {
    logic div_last;    // final quotient bit in this cycle
    logic out_free;    // output register can take a result
  } trc_status_t;

  function automatic logic is_vowel(input logic [7:0] c);
    return (c == "a") || (c == "e") || (c == "i") || (c == "o") || (c == "u") ||
           (c == "A") || (c == "E") || (c == "I") || (c == "O") || (c == "U");
  endfunction

  function automatic logic is_mark(input logic [7:0] c);
    return (c == CHAR_PERIOD) || (c == CHAR_SEMI) ||
           (c == CHAR_EXCLAIM) || (c == CHAR_QUESTION);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/trc_if.sv -----
`default_nettype none

// byte request channel
interface trc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

// result request channel
interface trc_result_if;
  logic               valid;
  logic               ready;
  logic [15:0]        char_total;
  logic [15:0]        word_total;
  logic [15:0]        sentence_total;
  logic [15:0]        syllable_total;
  logic signed [23:0] reading_score;
  logic               no_sentence_error;

  modport source (output valid, output char_total, output word_total,
                  output sentence_total, output syllable_total,
                  output reading_score, output no_sentence_error, input ready);
  modport sink   (input valid, input char_total, input word_total,
                  input sentence_total, input syllable_total,
                  input reading_score, input no_sentence_error, output ready);
endinterface

`default_nettype wire

// ----- rtl/text_readability_counter.sv -----
// sequence: after the final byte of a text the controller runs the two divisions
//   and then writes the result into the output register once that register is free
// throughput: one byte per cycle; after a final byte no byte is taken until the
//   two divisions of the bit-serial divider are done and the output register is free
// reset: asynchronous active low, clears counters, state and the result valid
`default_nettype none

module text_readability_counter #(
  parameter int unsigned COUNT_BITS = 16  // counter width, 8 to 32
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  trc_byte_if.sink      byte_i,
  trc_result_if.source  result_o
);
  import trc_pkg::*;

  // command and status between controller and datapath
  trc_cmd_t    cmd;
  trc_status_t status;

  // controller: counts bytes in its idle state, then sequences the two
  // divisions (words per sentence, syllables per word) and the result write
  trc_controller u_controller (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (byte_i.valid),
    .in_last_i  (byte_i.last_byte),
    .in_ready_o (byte_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath: saturating counters, token scoring, snapshot of one text,
  // shared restoring divider and the output register that decouples the
  // result request from the next text
  trc_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .text_byte_i         (byte_i.text_byte),
    .out_valid_o         (result_o.valid),
    .out_ready_i         (result_o.ready),
    .char_total_o        (result_o.char_total),
    .word_total_o        (result_o.word_total),
    .sentence_total_o    (result_o.sentence_total),
    .syllable_total_o    (result_o.syllable_total),
    .reading_score_o     (result_o.reading_score),
    .no_sentence_error_o (result_o.no_sentence_error)
  );

endmodule

`default_nettype wire

// ----- rtl/trc_controller.sv -----
`default_nettype none

module trc_controller (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_last_i,
  output logic                  in_ready_o,
  input  trc_pkg::trc_status_t  status_i,
  output trc_pkg::trc_cmd_t     cmd_o
);
  import trc_pkg::*;

  trc_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_COUNT: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_last_i) begin
            cmd_o.close_text = 1'b1;
            state_d          = ST_LOAD1;
          end else begin
            cmd_o.count = 1'b1;
          end
        end
      end
      ST_LOAD1: begin
        cmd_o.load_t1 = 1'b1;
        state_d       = ST_DIV1;
      end
      ST_DIV1: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = ST_LOAD2;
      end
      ST_LOAD2: begin
        cmd_o.load_t2 = 1'b1;
        state_d       = ST_DIV2;
      end
      ST_DIV2: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_COUNT;
        end
      end
      default: state_d = ST_COUNT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COUNT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/trc_datapath.sv -----
`default_nettype none

module trc_datapath #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  trc_pkg::trc_cmd_t    cmd_i,
  output trc_pkg::trc_status_t status_o,
  input  logic [7:0]           text_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [15:0]          char_total_o,
  output logic [15:0]          word_total_o,
  output logic [15:0]          sentence_total_o,
  output logic [15:0]          syllable_total_o,
  output logic signed [23:0]   reading_score_o,
  output logic                 no_sentence_error_o
);
  import trc_pkg::*;

  localparam int unsigned NumW = COUNT_BITS + 25;
  localparam int unsigned DenW = COUNT_BITS + 10;
  localparam int unsigned CntW = $clog2(NumW + 1);
  localparam int unsigned CB   = COUNT_BITS;

  function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] a,
                                            input logic [CB-1:0] b);
    logic [CB:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CB] ? {CB{1'b1}} : s[CB-1:0];
  endfunction

  function automatic logic [SCORE_W-1:0] sat_quot(input logic [NumW-1:0] q);
    return (|q[NumW-1:SCORE_W]) ? {SCORE_W{1'b1}} : q[SCORE_W-1:0];
  endfunction

  // running counters
  logic [CB-1:0] byte_q, space_q, mark_q, syl_q, vow_q;
  logic [2:0]    tlen_q;

  // per-text snapshot
  logic [CB-1:0] c_q, w_q, s_q, y_q;

  // divider
  logic [NumW-1:0]    num_q;
  logic [DenW-1:0]    den_q, rem_q;
  logic [CntW-1:0]    cnt_q;
  logic [SCORE_W-1:0] t1_q;

  // output register
  logic                      out_valid_q;
  logic [15:0]               char_q, word_q, sent_q, syll_q;
  logic signed [SCORE_W-1:0] score_q;
  logic                      err_q;

  logic          is_space, vowel, mark, close_now;
  logic [CB-1:0] byte_n, space_n, mark_n, vow_ext, close_vow, syl_add, syl_n, word_n;
  logic [2:0]    tlen_ext, close_len;

  logic [DenW:0]   rem_sh;
  logic            rem_ge;
  logic [DenW-1:0] rem_next;

  logic [SCORE_W-1:0]             t2_sat;
  logic signed [SCORE_CALC_W-1:0] diff, diff_clamped;

  always_comb begin
    is_space = (text_byte_i == CHAR_SPACE);
    vowel    = is_vowel(text_byte_i);
    mark     = is_mark(text_byte_i);

    byte_n   = sat_inc(byte_q, CB'(1));
    space_n  = is_space ? sat_inc(space_q, CB'(1)) : space_q;
    mark_n   = (!is_space && mark) ? sat_inc(mark_q, CB'(1)) : mark_q;
    tlen_ext = (tlen_q < TOKEN_LONG) ? tlen_q + 3'd1 : tlen_q;
    vow_ext  = vowel ? sat_inc(vow_q, CB'(1)) : vow_q;

    // a space closes the open token, the final byte closes the extended one
    close_now = is_space || cmd_i.close_text;
    close_len = is_space ? tlen_q : tlen_ext;
    close_vow = is_space ? vow_q : vow_ext;
    if (close_len == 3'd0) begin
      syl_add = '0;
    end else if (close_len <= TOKEN_SHORT) begin
      syl_add = CB'(1);
    end else begin
      syl_add = close_vow;
    end
    syl_n  = close_now ? sat_inc(syl_q, syl_add) : syl_q;
    word_n = sat_inc(space_n, CB'(1));
  end

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh   = {rem_q, num_q[NumW-1]};
    rem_ge   = rem_sh >= {1'b0, den_q};
    rem_next = rem_ge ? DenW'(rem_sh - {1'b0, den_q}) : rem_sh[DenW-1:0];
  end

  always_comb begin
    t2_sat = sat_quot(num_q);
    diff   = SCORE_BASE - $signed({3'b000, t1_q}) - $signed({3'b000, t2_sat});
    priority if (diff > SCORE_MAX) begin
      diff_clamped = SCORE_MAX;
    end else if (diff < SCORE_MIN) begin
      diff_clamped = SCORE_MIN;
    end else begin
      diff_clamped = diff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q  <= '0;
      space_q <= '0;
      mark_q  <= '0;
      syl_q   <= '0;
      vow_q   <= '0;
      tlen_q  <= '0;
    end else if (cmd_i.close_text) begin
      byte_q  <= '0;
      space_q <= '0;
      mark_q  <= '0;
      syl_q   <= '0;
      vow_q   <= '0;
      tlen_q  <= '0;
    end else if (cmd_i.count) begin
      byte_q  <= byte_n;
      space_q <= space_n;
      mark_q  <= mark_n;
      syl_q   <= syl_n;
      vow_q   <= is_space ? '0 : vow_ext;
      tlen_q  <= is_space ? 3'd0 : tlen_ext;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.close_text) begin
      c_q <= byte_n;
      w_q <= word_n;
      s_q <= mark_n;
      y_q <= syl_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load_t1 || cmd_i.load_t2) begin
      cnt_q <= CntW'(NumW);
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_t1) begin
      num_q <= NumW'(T1_W_SCALE) * NumW'(w_q) + NumW'(ROUND_HALF) * NumW'(s_q);
      den_q <= DenW'(DEN_SCALE) * DenW'(s_q);
      rem_q <= '0;
    end else if (cmd_i.load_t2) begin
      t1_q  <= sat_quot(num_q);
      num_q <= NumW'(T2_Y_SCALE) * NumW'(y_q) + NumW'(ROUND_HALF) * NumW'(w_q);
      den_q <= DenW'(DEN_SCALE) * DenW'(w_q);
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      num_q <= {num_q[NumW-2:0], rem_ge};
      rem_q <= rem_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      char_q  <= TOTAL_W'(c_q);
      word_q  <= TOTAL_W'(w_q);
      sent_q  <= TOTAL_W'(s_q);
      syll_q  <= TOTAL_W'(y_q);
      err_q   <= (s_q == '0);
      score_q <= (s_q == '0) ? '0 : diff_clamped[SCORE_W-1:0];
    end
  end

  assign status_o.div_last = (cnt_q == CntW'(1));
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o         = out_valid_q;
  assign char_total_o        = char_q;
  assign word_total_o        = word_q;
  assign sentence_total_o    = sent_q;
  assign syllable_total_o    = syll_q;
  assign reading_score_o     = score_q;
  assign no_sentence_error_o = err_q;

endmodule

`default_nettype wire

// ----- rtl/trc_checker.sv -----
`default_nettype none
`include "text_readability_counter_macros.svh"

module trc_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_i,
  input wire logic               in_last_i,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire logic [15:0]        sentence_total_i,
  input wire logic signed [23:0] reading_score_i,
  input wire logic               no_sentence_error_i
);

  // a stalled result request keeps its payload
  `TRC_ASSERT(a_result_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(reading_score_i) && $stable(sentence_total_i) && $stable(no_sentence_error_i), "result changed while stalled")

  // the final byte of a text starts the score computation
  `TRC_ASSERT(a_last_stalls_input, in_valid_i && in_ready_i && in_last_i |=> !in_ready_i, "byte taken right after final byte")

  // no sentence mark means no score
  `TRC_ASSERT(a_error_score_zero, out_valid_i && no_sentence_error_i |-> reading_score_i == 24'sd0, "score nonzero with error")

  `TRC_ASSERT(a_error_no_marks, out_valid_i && no_sentence_error_i |-> sentence_total_i == 16'd0, "error with sentence marks")

endmodule

bind text_readability_counter trc_checker u_trc_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (byte_i.valid),
  .in_ready_i          (byte_i.ready),
  .in_last_i           (byte_i.last_byte),
  .out_valid_i         (result_o.valid),
  .out_ready_i         (result_o.ready),
  .sentence_total_i    (result_o.sentence_total),
  .reading_score_i     (result_o.reading_score),
  .no_sentence_error_i (result_o.no_sentence_error)
);

`default_nettype wire
